// ===== sv/grd_pkg.sv =====
// Shared types, codes and the gamma table of the glyph row run-length decoder.
// Used by every module of the block; depends on nothing.
package grd_pkg;

    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [7:0] TOK_END_ROW = 8'h80;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TOKEN,
        PH_LITERAL,
        PH_REPEAT,
        PH_SKIP,
        PH_DONE,
        PH_FAILED
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       end_of_data;
    } grd_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pixel_row;
        logic [7:0] pixel_column;
        logic [7:0] coverage;
        logic       last_of_run;
    } grd_out_t;

    typedef struct packed {
        logic [5:0] pix_count;
        logic [7:0] row;
        logic [7:0] column;
        logic [7:0] coverage;
        logic       has_status;
        logic [1:0] status;
    } grd_job_t;

    function automatic logic [7:0] gamma_lookup(input logic [4:0] idx);
        logic [7:0] val;
        case (idx)
            5'd0:  val = 8'd1;
            5'd1:  val = 8'd1;
            5'd2:  val = 8'd2;
            5'd3:  val = 8'd4;
            5'd4:  val = 8'd5;
            5'd5:  val = 8'd7;
            5'd6:  val = 8'd10;
            5'd7:  val = 8'd13;
            5'd8:  val = 8'd16;
            5'd9:  val = 8'd20;
            5'd10: val = 8'd25;
            5'd11: val = 8'd30;
            5'd12: val = 8'd35;
            5'd13: val = 8'd41;
            5'd14: val = 8'd47;
            5'd15: val = 8'd55;
            5'd16: val = 8'd62;
            5'd17: val = 8'd71;
            5'd18: val = 8'd79;
            5'd19: val = 8'd89;
            5'd20: val = 8'd99;
            5'd21: val = 8'd110;
            5'd22: val = 8'd121;
            5'd23: val = 8'd133;
            5'd24: val = 8'd146;
            5'd25: val = 8'd159;
            5'd26: val = 8'd174;
            5'd27: val = 8'd188;
            5'd28: val = 8'd204;
            5'd29: val = 8'd220;
            5'd30: val = 8'd237;
            5'd31: val = 8'd255;
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== sv/grd_front.sv =====
// Front end: takes compressed bytes, parses row headers and tokens, and
// turns each byte with pixels or a status into one back-end job. Depends on grd_pkg.
module grd_front
    import grd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_write,
    input  logic     cfg_index,
    input  logic [7:0] cfg_data,
    input  logic     byte_valid,
    output logic     byte_ready,
    input  grd_in_t  byte_item,
    input  logic     queue_full,
    output logic     job_push,
    output grd_job_t job
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  hdr_seen_reg, hdr_seen_next;
    logic [23:0] size_shift_reg, size_shift_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [6:0]  run_left_reg, run_left_next;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic [7:0]  width_reg, height_reg;

    logic        accept;
    logic        job_want;
    grd_job_t    step_job;

    always_comb
    begin
        phase_t      ph;
        logic [1:0]  hb;
        logic [23:0] shift;
        logic [31:0] rbl;
        logic [31:0] size;
        logic [6:0]  run;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [7:0]  b;
        logic [8:0]  sum;
        logic [8:0]  lim;
        logic [7:0]  rows;
        logic        bad;
        logic        ok;

        b     = byte_item.data_byte;
        ph    = byte_item.first_byte ? PH_HEADER : phase_reg;
        hb    = byte_item.first_byte ? 2'd0 : hdr_seen_reg;
        shift = byte_item.first_byte ? 24'd0 : size_shift_reg;
        rbl   = byte_item.first_byte ? 32'd0 : bytes_left_reg;
        run   = byte_item.first_byte ? 7'd0 : run_left_reg;
        row   = byte_item.first_byte ? 8'd0 : row_reg;
        col   = byte_item.first_byte ? 8'd0 : col_reg;
        size  = {b, shift};
        sum   = 9'd0;
        lim   = 9'd0;
        rows  = (height_reg == 8'd0) ? 8'd1 : height_reg;
        bad   = 1'b0;
        ok    = 1'b0;

        step_job            = '0;
        step_job.row        = row;
        step_job.column     = col;
        step_job.coverage   = gamma_lookup(b[4:0]);

        if (ph == PH_DONE || ph == PH_FAILED)
        begin
            // Finished glyph: the byte is dropped.
        end
        else if (ph == PH_HEADER)
        begin
            if (hb == 2'd3)
            begin
                hb    = 2'd0;
                shift = 24'd0;
                if (size <= 32'd4)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    rbl = size - 32'd4;
                    col = 8'd0;
                    ph  = PH_TOKEN;
                end
            end
            else
            begin
                case (hb)
                    2'd0:    shift[7:0]   = b;
                    2'd1:    shift[15:8]  = b;
                    default: shift[23:16] = b;
                endcase
                hb = hb + 2'd1;
            end
        end
        else
        begin
            if (rbl != 32'd0)
            begin
                rbl = rbl - 32'd1;
            end
            case (ph)
                PH_TOKEN:
                begin
                    if (b == TOK_END_ROW)
                    begin
                        ph = PH_SKIP;
                    end
                    else if (b[7])
                    begin
                        if ({25'd0, b[6:0]} > rbl)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            run = b[6:0];
                            ph  = PH_LITERAL;
                        end
                    end
                    else if (b[6])
                    begin
                        sum = {1'b0, col} + {3'd0, b[5:0]};
                        col = sum[8] ? 8'hFF : sum[7:0];
                    end
                    else if (b == 8'd0 || rbl == 32'd0)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        run = b[6:0];
                        ph  = PH_REPEAT;
                    end
                end
                PH_LITERAL:
                begin
                    step_job.pix_count = (col < width_reg) ? 6'd1 : 6'd0;
                    col = (col == 8'hFF) ? 8'hFF : col + 8'd1;
                    if (run != 7'd0)
                    begin
                        run = run - 7'd1;
                    end
                    if (run == 7'd0)
                    begin
                        ph = PH_TOKEN;
                    end
                end
                PH_REPEAT:
                begin
                    sum = {1'b0, col} + {2'd0, run};
                    lim = (sum < {1'b0, width_reg}) ? sum : {1'b0, width_reg};
                    if (col < width_reg)
                    begin
                        step_job.pix_count = 6'(lim - {1'b0, col});
                    end
                    col = sum[8] ? 8'hFF : sum[7:0];
                    run = 7'd0;
                    ph  = PH_TOKEN;
                end
                default:
                begin
                end
            endcase
            if (!bad && (ph == PH_TOKEN || ph == PH_SKIP) && rbl == 32'd0)
            begin
                if ({1'b0, row} + 9'd1 >= {1'b0, rows})
                begin
                    ok = 1'b1;
                    ph = PH_DONE;
                end
                else
                begin
                    row = row + 8'd1;
                    col = 8'd0;
                    ph  = PH_HEADER;
                end
            end
        end

        if (bad || (byte_item.end_of_data && ph != PH_DONE && ph != PH_FAILED))
        begin
            ph = PH_FAILED;
            step_job.has_status = 1'b1;
            step_job.status     = KIND_BAD;
        end
        else if (ok)
        begin
            step_job.has_status = 1'b1;
            step_job.status     = KIND_OK;
        end

        phase_next      = ph;
        hdr_seen_next   = hb;
        size_shift_next = shift;
        bytes_left_next = rbl;
        run_left_next   = run;
        row_next        = row;
        col_next        = col;
    end

    always_comb
    begin
        byte_ready = !queue_full;
        accept     = byte_valid && byte_ready;
        job_want   = step_job.has_status || (step_job.pix_count != 6'd0);
        job_push   = accept && job_want;
        job        = step_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            hdr_seen_reg   <= 2'd0;
            size_shift_reg <= 24'd0;
            bytes_left_reg <= 32'd0;
            run_left_reg   <= 7'd0;
            row_reg        <= 8'd0;
            col_reg        <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            hdr_seen_reg   <= hdr_seen_next;
            size_shift_reg <= size_shift_next;
            bytes_left_reg <= bytes_left_next;
            run_left_reg   <= run_left_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd1;
            height_reg <= 8'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    a_pixels_inside_width: assert property (@(posedge clk) disable iff (!rst_n)
        job_push && job.pix_count != 6'd0
            |-> ({1'b0, job.column} + {3'd0, job.pix_count}) <= {1'b0, width_reg})
        else $error("pixel job reaches past the glyph width");

    a_finished_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_item.first_byte
            && (phase_reg == PH_DONE || phase_reg == PH_FAILED) |-> !job_push)
        else $error("job issued for a finished glyph");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !job_push)
        else $error("job pushed into a full queue");

endmodule

// ===== sv/grd_queue.sv =====
// Short job queue between the front and back ends of the decoder.
// Depends on grd_pkg for the job type and the queue depth.
module grd_queue
    import grd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  grd_job_t push_job,
    output logic     full,
    input  logic     pop,
    output grd_job_t head,
    output logic     empty
);

    grd_job_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]     count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
        empty       = (count_reg == '0);
        head        = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from an empty queue");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> !empty)
        else $error("queue lost a pushed job");

    a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_PTR_W-1:0])
        else $error("queue pointers disagree with the count");

endmodule

// ===== sv/grd_back.sv =====
// Back end: expands one job at a time into pixel writes and a status
// report, held in output registers. Depends on grd_pkg.
module grd_back
    import grd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     queue_empty,
    input  grd_job_t head,
    output logic     pop,
    output logic     result_valid,
    input  logic     result_ready,
    output grd_out_t result_item
);

    logic       busy_reg, busy_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [7:0] row_reg, row_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] cov_reg, cov_next;
    logic       st_valid_reg, st_valid_next;
    logic [1:0] st_kind_reg, st_kind_next;

    logic       pixel;
    logic       last;
    logic       fire;

    always_comb
    begin
        pixel = (cnt_reg != 6'd0);
        last  = pixel ? (cnt_reg == 6'd1 && !st_valid_reg) : 1'b1;
        fire  = busy_reg && result_ready;
        pop   = !queue_empty && (!busy_reg || (fire && last));

        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cov_next      = cov_reg;
        st_valid_next = st_valid_reg;
        st_kind_next  = st_kind_reg;

        if (pop)
        begin
            busy_next     = 1'b1;
            cnt_next      = head.pix_count;
            row_next      = head.row;
            col_next      = head.column;
            cov_next      = head.coverage;
            st_valid_next = head.has_status;
            st_kind_next  = head.status;
        end
        else if (fire)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
                col_next = col_reg + 8'd1;
            end
        end
    end

    always_comb
    begin
        result_valid             = busy_reg;
        result_item.kind         = pixel ? KIND_PIXEL : st_kind_reg;
        result_item.pixel_row    = pixel ? row_reg : 8'd0;
        result_item.pixel_column = pixel ? col_reg : 8'd0;
        result_item.coverage     = pixel ? cov_reg : 8'd0;
        result_item.last_of_run  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cnt_reg      <= 6'd0;
            st_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            cnt_reg      <= cnt_next;
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        cov_reg     <= cov_next;
        st_kind_reg <= st_kind_next;
    end

    a_job_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg == 6'd0 |-> st_valid_reg)
        else $error("active job has nothing left to report");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !last |=> busy_reg)
        else $error("job dropped before its last result");

    a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && st_valid_reg |-> st_kind_reg == KIND_OK || st_kind_reg == KIND_BAD)
        else $error("status report carries a pixel kind");

endmodule

// ===== sv/glyph_rle_row_decoder.sv =====
// Glyph row run-length decoder, top level: front end, job queue, back end.
// Depends on grd_pkg, grd_front, grd_queue and grd_back.
//
//   channel   direction  handshake                      payload
//   byte      in         byte_valid / byte_ready        byte_item (grd_in_t)
//   result    out        result_valid / result_ready    result_item (grd_out_t)
//   config    in         cfg_write                      cfg_index, cfg_data
//
// A byte is taken every cycle while the four-entry job queue has room.
// A byte's job goes through a queue slot and then the back-end registers
// before its first result shows; a repeat run holds the result register for
// one result per pixel, so sustained input follows the result side once the
// queue fills. Bytes that cause no result never reach the queue.
// Reset clears the decoder state and sets width and height to one.
module glyph_rle_row_decoder
    import grd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  grd_in_t    byte_item,
    output logic       result_valid,
    input  logic       result_ready,
    output grd_out_t   result_item
);

    logic     queue_full;
    logic     queue_empty;
    logic     job_push;
    logic     job_pop;
    grd_job_t job_in;
    grd_job_t job_head;

    grd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (job_in)
    );

    grd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job_in),
        .full     (queue_full),
        .pop      (job_pop),
        .head     (job_head),
        .empty    (queue_empty)
    );

    grd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .head         (job_head),
        .pop          (job_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule
